### hw/rtl/thorp_pkg.sv
// Package for the Thorp transmission loss unit: field widths, fixed-point
// constants, spreading band codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package thorp_pkg;

    // Field widths
    localparam int FREQ_W     = 14;
    localparam int LIMIT_W    = 20;
    localparam int ABS_W      = 17;
    localparam int LOSS_W     = 24;
    localparam int SQ_W       = 28;   // frequency squared
    localparam int A24_W      = 33;   // alpha in Q24

    // Parameter defaults
    localparam int DISTANCE_WIDTH_DEF = 20;
    localparam int LOSS_FRAC_BITS_DEF = 8;

    // Register reset values
    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST = 20'd500;
    localparam logic [LIMIT_W-1:0] MID_LIMIT_RST  = 20'd2000;

    // Output clamps
    localparam logic [ABS_W-1:0]  ABS_MAX  = '1;
    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

    // Alpha term 1: 11*2^24*S / (100*(256+S))
    localparam int R1_W = 56;
    localparam int D1_W = 35;
    localparam int Q1_W = 21;
    // Alpha term 2: 44*2^24*S / (1049600+S)
    localparam int R2_W = 58;
    localparam int D2_W = 29;
    localparam int Q2_W = 30;
    // Alpha term 3: 275*65536*S / 1e6 == 11264*S / 625 == 18*S + 14*S/625
    localparam int Q3_W  = 33;
    localparam int T3X_W = 32;        // 14*S
    localparam int T3F_W = 23;        // 14*S/625
    localparam logic [4:0]  T3_INT   = 5'd18;
    localparam logic [3:0]  T3_REM   = 4'd14;
    localparam int          T3_SH    = 42;
    localparam logic [32:0] T3_RECIP = 33'd7036874418;   // ceil(2^42/625), exact below 2^32
    // Alpha term 4: floor(3*2^24/1000)
    localparam logic [A24_W-1:0] T4_CONST = 33'd50331;

    // Absorb term: alpha24>>8 split as Ah*1000 + Al
    localparam int A_W  = A24_W - 8;
    localparam int AH_W = 16;
    localparam int A1000_SH = 35;
    localparam logic [25:0] A1000_RECIP = 26'd34359739;  // ceil(2^35/1000), exact below 2^25
    localparam logic [9:0]  K1000 = 10'd1000;

    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

    // Spreading multipliers (k*10)
    localparam int MULT_NEAR = 30;
    localparam int MULT_MID  = 20;
    localparam int MULT_FAR  = 15;

    typedef enum logic [1:0] {
        BAND_NEAR,
        BAND_MID,
        BAND_FAR
    } band_t;

    typedef enum logic {
        REG_NEAR_LIMIT = 1'b0,
        REG_MID_LIMIT  = 1'b1
    } cfg_index_t;

endpackage

### hw/rtl/thorp_transmission_loss_db_unit.sv
// Thorp transmission loss unit, top level: fully pipelined absorption and
// spreading loss in fixed point. Depends on thorp_pkg.
// Pipeline depth: independent of the distance width; set by the 30-step
//   restoring dividers of the two frequency-dependent alpha terms, the alpha
//   sum and a reciprocal divide by 1000 of the absorption term.
// Throughput: one transfer per cycle; each stage holds only while the stage
//   after it is full and stalled.
// Reset: aresetn synchronous, active low; clears stage valid bits and loads
//   the band limits with 500 m and 2000 m.
`timescale 1ns / 1ps

module thorp_transmission_loss_db_unit #(
    parameter int DISTANCE_WIDTH = thorp_pkg::DISTANCE_WIDTH_DEF,
    parameter int LOSS_FRAC_BITS = thorp_pkg::LOSS_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [thorp_pkg::LIMIT_W-1:0] cfg_data,
    // Query stream
    input  logic s_tvalid,
    output logic s_tready,
    // {distance_m, frequency_khz_q4, pad} from bit 0 up
    input  logic [((DISTANCE_WIDTH+thorp_pkg::FREQ_W+7)/8)*8-1:0] s_tdata,
    // Result stream
    output logic m_tvalid,
    input  logic m_tready,
    // {absorption_q8, loss_q8, pad} from bit 0 up
    output logic [47:0] m_tdata,
    // {saturated, distance_zero} from bit 0 up
    output logic [1:0]  m_tuser
);
    import thorp_pkg::*;

    localparam int DW     = DISTANCE_WIDTH;
    localparam int CMP_W  = (DW > LIMIT_W) ? DW : LIMIT_W;
    localparam int IPW    = $clog2(DW);
    localparam int LGW    = IPW + 16;          // log2 in Q16
    localparam int MLW    = LGW + 5;           // times spreading multiplier
    localparam int SPP_W  = MLW + 31;          // times log10(2) in Q32
    localparam int Q4_W   = DW + 16;           // absorb16 quotient
    localparam int Y_W    = DW + 10;           // d*Al + 500
    localparam int Y_SH   = Y_W + 10;
    localparam int YM_W   = DW + 11;
    localparam int TOT_W  = ((MLW > Q4_W) ? MLW : Q4_W) + 1;
    localparam int ABS_SH = 24 - LOSS_FRAC_BITS;
    localparam int LSH    = 16 - LOSS_FRAC_BITS;

    localparam logic [A24_W:0]   ABS_RND  = (A24_W+1)'((2**ABS_SH) / 2);
    localparam logic [TOT_W:0]   LOSS_RND = (TOT_W+1)'((2**LSH) / 2);
    localparam logic [Y_W-1:0]   HALF1000 = Y_W'(500);
    // ceil(2^Y_SH/1000): exact floor division for every Y_W-bit value
    localparam logic [YM_W-1:0]  Y_RECIP  = YM_W'(((64'd1 << Y_SH) + 64'd999) / 64'd1000);

    // Stage map
    localparam int ST_IN       = 0;   // input capture
    localparam int ST_SQ       = 1;   // F*F, leading one, band
    localparam int ST_PREP     = 2;   // divider operands, mantissa
    localparam int ST_T3MUL    = ST_PREP + 1;
    localparam int ST_T3SUM    = ST_PREP + 2;
    localparam int DIV_STEPS   = Q2_W;
    localparam int ST_DIV_END  = ST_PREP + DIV_STEPS;
    localparam int ST_LOG_END  = ST_PREP + 16;
    localparam int ST_MLOG     = ST_LOG_END + 1;
    localparam int ST_SPROD    = ST_MLOG + 1;
    localparam int ST_SPREAD   = ST_SPROD + 1;
    localparam int ST_SUM      = ST_DIV_END + 1;
    localparam int ST_MUL      = ST_SUM + 1;    // Ah estimate
    localparam int ST_AL       = ST_MUL + 1;    // Al = A - 1000*Ah
    localparam int ST_Y        = ST_AL + 1;     // d*Al + 500, d*Ah
    localparam int ST_YQ       = ST_Y + 1;      // (d*Al + 500) / 1000
    localparam int ST_ADIV_END = ST_YQ + 1;
    localparam int ST_OUT      = ST_ADIV_END + 1;
    localparam int NSTG        = ST_OUT + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [LIMIT_W-1:0] near_limit_reg;
    logic [LIMIT_W-1:0] mid_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_limit_reg <= NEAR_LIMIT_RST;
            mid_limit_reg  <= MID_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_NEAR_LIMIT: near_limit_reg <= cfg_data;
                REG_MID_LIMIT:  mid_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage valids and load enables. A stage loads when it is empty or
    // its content moves on this cycle.
    // ---------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign s_tready = en[0];

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    logic [DW-1:0]     dist_reg  [ST_IN:ST_OUT-1];
    logic [FREQ_W-1:0] freq_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [IPW-1:0]    ip_reg    [ST_SQ:ST_LOG_END];
    band_t             band_reg  [ST_SQ:ST_LOG_END];
    logic [30:0]       mant_reg  [ST_PREP:ST_LOG_END];
    logic [15:0]       frac_reg  [ST_PREP:ST_LOG_END];
    logic [MLW-1:0]    mlog_reg;
    logic [SPP_W-1:0]  sprod_reg;
    logic [MLW-1:0]    spread_reg [ST_SPREAD:ST_OUT-1];

    logic [R1_W-1:0]   rem1_reg  [ST_PREP:ST_DIV_END];
    logic [Q1_W-1:0]   q1_reg    [ST_PREP:ST_DIV_END];
    logic [D1_W-1:0]   den1_reg  [ST_PREP:ST_DIV_END-1];
    logic [R2_W-1:0]   rem2_reg  [ST_PREP:ST_DIV_END];
    logic [Q2_W-1:0]   q2_reg    [ST_PREP:ST_DIV_END];
    logic [D2_W-1:0]   den2_reg  [ST_PREP:ST_DIV_END-1];
    logic [T3X_W-1:0]  t3x_reg;
    logic [Q3_W-1:0]   t3b_reg   [ST_PREP:ST_T3MUL];
    logic [T3F_W-1:0]  t3f_reg;
    logic [Q3_W-1:0]   q3_reg    [ST_T3SUM:ST_DIV_END];

    logic [A24_W-1:0]  a24_reg;
    logic [ABS_W-1:0]  abs_reg   [ST_MUL:ST_OUT];
    logic [A_W-1:0]    a_reg;
    logic [AH_W-1:0]   ah_reg    [ST_MUL:ST_AL];
    logic [9:0]        al_reg;
    logic [Y_W-1:0]    y_reg;
    logic [Q4_W-1:0]   dah_reg   [ST_Y:ST_YQ];
    logic [DW-1:0]     yq_reg;
    logic [Q4_W-1:0]   q4_reg;

    logic [LOSS_W-1:0] loss_reg;
    logic              sat_reg;
    logic              zero_reg;

    // Stage 0: capture the transfer
    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            dist_reg[ST_IN] <= s_tdata[DW-1:0];
            freq_reg        <= s_tdata[DW+FREQ_W-1:DW];
        end
    end

    // Distance travels along the whole pipe
    for (genvar k = ST_IN + 1; k < ST_OUT; k++) begin : g_dist
        always_ff @(posedge aclk) begin
            if (en[k]) dist_reg[k] <= dist_reg[k-1];
        end
    end

    // Stage 1: square, leading-one position, spreading band
    logic [IPW-1:0] ip_next;
    band_t          band_next;

    always_comb begin
        ip_next = '0;
        for (int i = 0; i < DW; i++) begin
            if (dist_reg[ST_IN][i]) ip_next = IPW'(i);
        end
        if (CMP_W'(dist_reg[ST_IN]) <= CMP_W'(near_limit_reg)) begin
            band_next = BAND_NEAR;
        end else if (CMP_W'(dist_reg[ST_IN]) <= CMP_W'(mid_limit_reg)) begin
            band_next = BAND_MID;
        end else begin
            band_next = BAND_FAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SQ]) begin
            sq_reg          <= SQ_W'(freq_reg) * SQ_W'(freq_reg);
            ip_reg[ST_SQ]   <= ip_next;
            band_reg[ST_SQ] <= band_next;
        end
    end

    for (genvar k = ST_SQ + 1; k <= ST_LOG_END; k++) begin : g_ipband
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                ip_reg[k]   <= ip_reg[k-1];
                band_reg[k] <= band_reg[k-1];
            end
        end
    end

    // Stage 2: divider operands and Q30 mantissa
    logic [DW+29:0] mant_wide;
    logic [31:0]    n1_hi;
    logic [33:0]    n2_hi;

    always_comb begin
        mant_wide = {dist_reg[ST_SQ], 30'b0} >> ip_reg[ST_SQ];
        n1_hi     = 32'(sq_reg) * 32'd11;
        n2_hi     = 34'(sq_reg) * 34'd44;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_PREP]) begin
            mant_reg[ST_PREP] <= mant_wide[30:0];
            frac_reg[ST_PREP] <= '0;
            rem1_reg[ST_PREP] <= {n1_hi, 24'b0};
            den1_reg[ST_PREP] <= D1_W'(sq_reg) * D1_W'(100) + D1_W'(25600);
            q1_reg[ST_PREP]   <= '0;
            rem2_reg[ST_PREP] <= {n2_hi, 24'b0};
            den2_reg[ST_PREP] <= D2_W'(sq_reg) + D2_W'(1049600);
            q2_reg[ST_PREP]   <= '0;
            t3x_reg           <= T3X_W'(sq_reg) * T3X_W'(T3_REM);
            t3b_reg[ST_PREP]  <= Q3_W'(sq_reg) * Q3_W'(T3_INT);
        end
    end

    // Alpha term 3 by reciprocal: 18*S + floor(14*S/625)
    logic [T3X_W+32:0] t3_prod;

    assign t3_prod = (T3X_W+33)'(t3x_reg) * (T3X_W+33)'(T3_RECIP);

    always_ff @(posedge aclk) begin
        if (en[ST_T3MUL]) begin
            t3f_reg           <= t3_prod[T3_SH+T3F_W-1:T3_SH];
            t3b_reg[ST_T3MUL] <= t3b_reg[ST_PREP];
        end
        if (en[ST_T3SUM]) q3_reg[ST_T3SUM] <= t3b_reg[ST_T3MUL] + Q3_W'(t3f_reg);
    end

    for (genvar k = ST_T3SUM + 1; k <= ST_DIV_END; k++) begin : g_q3
        always_ff @(posedge aclk) begin
            if (en[k]) q3_reg[k] <= q3_reg[k-1];
        end
    end

    // Log2 fraction: one square-and-compare step per stage
    for (genvar k = ST_PREP + 1; k <= ST_LOG_END; k++) begin : g_log
        logic [61:0] msq;
        assign msq = 62'(mant_reg[k-1]) * 62'(mant_reg[k-1]);
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                if (msq[61]) begin
                    mant_reg[k] <= msq[61:31];
                    frac_reg[k] <= {frac_reg[k-1][14:0], 1'b1};
                end else begin
                    mant_reg[k] <= msq[60:30];
                    frac_reg[k] <= {frac_reg[k-1][14:0], 1'b0};
                end
            end
        end
    end

    // Spreading term: k*10*log2(d)*log10(2)
    logic [LGW-1:0] log2_q16;
    logic [MLW-1:0] mlog_next;
    logic [SPP_W:0] spread_rnd;

    always_comb begin
        log2_q16 = {ip_reg[ST_LOG_END], frac_reg[ST_LOG_END]};
        case (band_reg[ST_LOG_END])
            BAND_NEAR: mlog_next = MLW'(log2_q16) * MLW'(MULT_NEAR);
            BAND_MID:  mlog_next = MLW'(log2_q16) * MLW'(MULT_MID);
            BAND_FAR:  mlog_next = MLW'(log2_q16) * MLW'(MULT_FAR);
            default:   mlog_next = MLW'(log2_q16) * MLW'(MULT_FAR);
        endcase
        spread_rnd = (SPP_W+1)'(sprod_reg) + (SPP_W+1)'(64'd2147483648);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_MLOG])   mlog_reg  <= mlog_next;
        if (en[ST_SPROD])  sprod_reg <= SPP_W'(mlog_reg) * SPP_W'(LOG10_2_Q32);
        if (en[ST_SPREAD]) spread_reg[ST_SPREAD] <= spread_rnd[SPP_W:32];
    end

    for (genvar k = ST_SPREAD + 1; k < ST_OUT; k++) begin : g_spread
        always_ff @(posedge aclk) begin
            if (en[k]) spread_reg[k] <= spread_reg[k-1];
        end
    end

    // Alpha dividers: restoring, one quotient bit per stage, MSB first
    for (genvar k = ST_PREP + 1; k <= ST_DIV_END; k++) begin : g_adiv
        localparam int J = ST_DIV_END - k;

        if (k < ST_DIV_END) begin : g_den
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    den1_reg[k] <= den1_reg[k-1];
                    den2_reg[k] <= den2_reg[k-1];
                end
            end
        end

        if (J < Q1_W) begin : g_t1
            logic [R1_W-1:0] sh1;
            assign sh1 = R1_W'(den1_reg[k-1]) << J;
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    if (rem1_reg[k-1] >= sh1) begin
                        rem1_reg[k] <= rem1_reg[k-1] - sh1;
                        q1_reg[k]   <= q1_reg[k-1] | (Q1_W'(1) << J);
                    end else begin
                        rem1_reg[k] <= rem1_reg[k-1];
                        q1_reg[k]   <= q1_reg[k-1];
                    end
                end
            end
        end else begin : g_t1_pass
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem1_reg[k] <= rem1_reg[k-1];
                    q1_reg[k]   <= q1_reg[k-1];
                end
            end
        end

        if (J < Q2_W) begin : g_t2
            logic [R2_W-1:0] sh2;
            assign sh2 = R2_W'(den2_reg[k-1]) << J;
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    if (rem2_reg[k-1] >= sh2) begin
                        rem2_reg[k] <= rem2_reg[k-1] - sh2;
                        q2_reg[k]   <= q2_reg[k-1] | (Q2_W'(1) << J);
                    end else begin
                        rem2_reg[k] <= rem2_reg[k-1];
                        q2_reg[k]   <= q2_reg[k-1];
                    end
                end
            end
        end else begin : g_t2_pass
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem2_reg[k] <= rem2_reg[k-1];
                    q2_reg[k]   <= q2_reg[k-1];
                end
            end
        end
    end

    // Alpha sum, then absorption output and Ah = floor((alpha24>>8)/1000)
    logic [A24_W:0]            abs_rnd;
    logic [A24_W-ABS_SH:0]     abs_sh;
    logic [A_W+25:0]           ah_prod;

    always_comb begin
        abs_rnd = (A24_W+1)'(a24_reg) + ABS_RND;
        abs_sh  = abs_rnd[A24_W:ABS_SH];
        ah_prod = (A_W+26)'(a24_reg[A24_W-1:8]) * (A_W+26)'(A1000_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            a24_reg <= A24_W'(q1_reg[ST_DIV_END]) + A24_W'(q2_reg[ST_DIV_END])
                     + q3_reg[ST_DIV_END] + T4_CONST;
        end
        if (en[ST_MUL]) begin
            a_reg          <= a24_reg[A24_W-1:8];
            ah_reg[ST_MUL] <= ah_prod[A1000_SH+AH_W-1:A1000_SH];
            if (abs_sh > (A24_W-ABS_SH+1)'(ABS_MAX)) begin
                abs_reg[ST_MUL] <= ABS_MAX;
            end else begin
                abs_reg[ST_MUL] <= ABS_W'(abs_sh);
            end
        end
    end

    for (genvar k = ST_MUL + 1; k <= ST_OUT; k++) begin : g_abs
        always_ff @(posedge aclk) begin
            if (en[k]) abs_reg[k] <= abs_reg[k-1];
        end
    end

    // absorb16 = d*Ah + floor((d*Al + 500)/1000), with Al = A - 1000*Ah
    logic [A_W-1:0]      al_full;
    logic [Y_W+YM_W-1:0] yq_prod;

    always_comb begin
        al_full = a_reg - A_W'(ah_reg[ST_MUL]) * A_W'(K1000);
        yq_prod = (Y_W+YM_W)'(y_reg) * (Y_W+YM_W)'(Y_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_AL]) begin
            al_reg        <= al_full[9:0];
            ah_reg[ST_AL] <= ah_reg[ST_MUL];
        end
        if (en[ST_Y]) begin
            y_reg         <= Y_W'(dist_reg[ST_AL]) * Y_W'(al_reg) + HALF1000;
            dah_reg[ST_Y] <= Q4_W'(dist_reg[ST_AL]) * Q4_W'(ah_reg[ST_AL]);
        end
        if (en[ST_YQ]) begin
            yq_reg         <= yq_prod[Y_SH+DW-1:Y_SH];
            dah_reg[ST_YQ] <= dah_reg[ST_Y];
        end
        if (en[ST_ADIV_END]) q4_reg <= dah_reg[ST_YQ] + Q4_W'(yq_reg);
    end

    // Output stage: total, round to Q.LOSS_FRAC_BITS, clamp, zero distance
    logic [TOT_W:0]     tot_rnd;
    logic [TOT_W-LSH:0] loss_sh;

    always_comb begin
        tot_rnd = (TOT_W+1)'(spread_reg[ST_OUT-1]) + (TOT_W+1)'(q4_reg)
                + LOSS_RND;
        loss_sh = tot_rnd[TOT_W:LSH];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            if (dist_reg[ST_OUT-1] == '0) begin
                loss_reg <= '0;
                sat_reg  <= 1'b0;
                zero_reg <= 1'b1;
            end else if (loss_sh > (TOT_W-LSH+1)'(LOSS_MAX)) begin
                loss_reg <= LOSS_MAX;
                sat_reg  <= 1'b1;
                zero_reg <= 1'b0;
            end else begin
                loss_reg <= LOSS_W'(loss_sh);
                sat_reg  <= 1'b0;
                zero_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = {7'b0, loss_reg, abs_reg[ST_OUT]};
    assign m_tuser  = {zero_reg, sat_reg};

`ifndef SYNTHESIS
    // An empty output stage frees every stage, so the input must be ready
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_zero_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[40:17] == '0 && !m_tuser[0]))
        else $error("zero distance with nonzero loss or saturation");

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[40:17] == LOSS_MAX))
        else $error("saturation flagged without clamped loss");
`endif

endmodule

### verif/tb_thorp_transmission_loss_db_unit.sv
// Self-checking testbench for the Thorp transmission loss unit: drives distance and
// frequency queries with random stalls and compares each result with a predicted value.
// Depends on thorp_pkg and thorp_transmission_loss_db_unit.
`timescale 1ns / 1ps

// Holds predicted loss results in arrival order and checks the results the DUT returns.
class loss_scoreboard;
    typedef struct {
        logic [16:0] absorption;
        logic [23:0] loss;
        logic        sat;
        logic        zero;
    } loss_result_t;

    loss_result_t pending_q[$];
    logic [19:0]  near_lim;
    logic [19:0]  mid_lim;
    int           errors;
    int           checked;

    function new();
        near_lim = thorp_pkg::NEAR_LIMIT_RST;
        mid_lim  = thorp_pkg::MID_LIMIT_RST;
        errors   = 0;
        checked  = 0;
    endfunction

    // log2(d) in Q16: integer part from the top set bit, 16 square-and-compare steps.
    function automatic logic [63:0] log2_q16(logic [63:0] d);
        int          ip;
        logic [63:0] m;
        logic [63:0] frac;
        ip   = 0;
        frac = 0;
        while (ip < 63 && (d >> (ip + 1)) != 0) ip++;
        m = (ip <= 30) ? (d << (30 - ip)) : (d >> (ip - 30));
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(ip) << 16) | frac;
    endfunction

    // Absorption coefficient in Q24 dB/km from frequency in sixteenths of a kHz.
    function automatic logic [63:0] alpha_q24(logic [13:0] fq4);
        logic [63:0] s;
        s = 64'(fq4) * 64'(fq4);
        return (64'd11 * (64'd1 << 24) * s) / (64'd100 * (64'd256 + s))
             + (64'd44 * (64'd1 << 24) * s) / (64'd1049600 + s)
             + (64'd275 * 64'd65536 * s) / 64'd1000000
             + (64'd3 * (64'd1 << 24)) / 64'd1000;
    endfunction

    // Mirror a register write into the prediction.
    function void write_limit(thorp_pkg::cfg_index_t idx, logic [19:0] val);
        if (idx == thorp_pkg::REG_NEAR_LIMIT) near_lim = val;
        else mid_lim = val;
    endfunction

    // Predict the result of an accepted query and queue it.
    function void note_query(logic [19:0] d, logic [13:0] fq4);
        loss_result_t r;
        logic [63:0]  a24;
        logic [63:0]  absorb;
        logic [63:0]  mult;
        logic [63:0]  spread16;
        logic [63:0]  absorb16;
        logic [63:0]  lossv;
        a24    = alpha_q24(fq4);
        absorb = (a24 + (64'd1 << 15)) >> 16;
        if (absorb > 64'h1FFFF) absorb = 64'h1FFFF;
        r.absorption = absorb[16:0];
        r.loss = '0;
        r.sat  = 1'b0;
        r.zero = 1'b0;
        if (d == 0) begin
            r.zero = 1'b1;
        end else begin
            if (d <= near_lim) mult = 64'(thorp_pkg::MULT_NEAR);
            else if (d <= mid_lim) mult = 64'(thorp_pkg::MULT_MID);
            else mult = 64'(thorp_pkg::MULT_FAR);
            spread16 = (mult * log2_q16(64'(d)) * 64'd1292913986 + (64'd1 << 31)) >> 32;
            absorb16 = (64'(d) * (a24 >> 8) + 64'd500) / 64'd1000;
            lossv    = (spread16 + absorb16 + 64'd128) >> 8;
            if (lossv > 64'hFFFFFF) begin
                lossv = 64'hFFFFFF;
                r.sat = 1'b1;
            end
            r.loss = lossv[23:0];
        end
        pending_q.push_back(r);
    endfunction

    // Compare one returned result with the oldest prediction.
    function void check_result(logic [47:0] tdata, logic [1:0] tuser);
        loss_result_t e;
        checked++;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: tdata=%h tuser=%b", tdata, tuser);
            return;
        end
        e = pending_q.pop_front();
        if (tdata[16:0] !== e.absorption || tdata[40:17] !== e.loss
                || tdata[47:41] !== 7'd0 || tuser[0] !== e.sat || tuser[1] !== e.zero) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch #%0d: abs exp %0d got %0d, loss exp %0d got %0d,",
                          " sat exp %b got %b, zero exp %b got %b"},
                         checked, e.absorption, tdata[16:0], e.loss, tdata[40:17],
                         e.sat, tuser[0], e.zero, tuser[1]);
        end
    endfunction
endclass

module tb_thorp_transmission_loss_db_unit;
    import thorp_pkg::*;

    localparam int LATENCY  = 40;
    localparam int WATCHDOG = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [19:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // {distance_m, frequency_khz_q4, pad} from bit 0 up
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // {absorption_q8, loss_q8, pad} from bit 0 up
    logic [1:0]  m_tuser;     // {saturated, distance_zero} from bit 0 up

    loss_scoreboard sb;
    int  send_idle_pct;       // chance per cycle that the sender holds off
    int  recv_stall_pct;      // chance per cycle that the receiver stalls
    int  quiet_cycles;        // cycles without any transfer, for the watchdog
    int  n_queries;
    int  n_configs;

    thorp_transmission_loss_db_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Receiver: random backpressure, result checking on every output transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without any transfer means the DUT is hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (sb.pending_q.size() != 0 || s_tvalid) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog timeout with %0d results outstanding", sb.pending_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // One query transfer, with optional idle cycles ahead of it.
    task automatic send_query(logic [19:0] d, logic [13:0] fq4);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, fq4, d};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_query(d, fq4);
        n_queries++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    // Register write while the pipeline is empty.
    task automatic write_limit(cfg_index_t idx, logic [19:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_limit(idx, val);
        n_configs++;
    endtask

    // Random query: mostly realistic distances and frequencies, some full range.
    task automatic random_query();
        logic [19:0] d;
        logic [13:0] f;
        case ($urandom_range(9))
            0: d = '0;
            1, 2: d = 20'($urandom_range(1 << 20) - 1);
            3: d = 20'($urandom_range(sb.near_lim + 1) + sb.near_lim - 1);
            4: d = 20'($urandom_range(sb.mid_lim + 1) + sb.mid_lim - 1);
            default: d = 20'($urandom_range(20000, 1));
        endcase
        f = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(1600));
        send_query(d, f);
    endtask

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_NEAR_LIMIT;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        n_queries      = 0;
        n_configs      = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, band edges at reset limits, zero distance.
        send_query(20'd0, 14'd0);
        send_query(20'd0, 14'h3FFF);
        send_query(20'd1, 14'd0);
        send_query(20'hFFFFF, 14'h3FFF);  // absorption term drives loss into saturation
        send_query(20'hFFFFF, 14'd0);
        send_query(20'd500, 14'd160);
        send_query(20'd501, 14'd160);
        send_query(20'd2000, 14'd160);
        send_query(20'd2001, 14'd160);
        send_query(20'h55555, 14'h2AAA);
        send_query(20'hAAAAA, 14'h1555);
        send_query(20'd1000, 14'd16);
        send_query(20'd1024, 14'd1);
        send_query(20'd3, 14'd8000);

        // Near limit above mid limit: mid band empty.
        write_limit(REG_NEAR_LIMIT, 20'd5000);
        write_limit(REG_MID_LIMIT, 20'd1000);
        send_query(20'd1500, 14'd100);
        send_query(20'd5000, 14'd100);
        send_query(20'd5001, 14'd100);
        // Extreme limits: everything near, then nothing but zero near.
        write_limit(REG_NEAR_LIMIT, 20'hFFFFF);
        send_query(20'hFFFFF, 14'd50);
        write_limit(REG_NEAR_LIMIT, 20'd0);
        write_limit(REG_MID_LIMIT, 20'd0);
        send_query(20'd1, 14'd50);
        send_query(20'd0, 14'd50);

        // Random phases, each under its own limit setting and idling mix.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_limit(REG_NEAR_LIMIT, 20'd500);
                    write_limit(REG_MID_LIMIT, 20'd2000);
                end
                1: begin
                    write_limit(REG_NEAR_LIMIT, 20'($urandom));
                    write_limit(REG_MID_LIMIT, 20'($urandom));
                end
                2: begin
                    write_limit(REG_NEAR_LIMIT, 20'd100);
                    write_limit(REG_MID_LIMIT, 20'hFFFFF);
                end
                3: begin
                    write_limit(REG_NEAR_LIMIT, 20'd3000);
                    write_limit(REG_MID_LIMIT, 20'd8000);
                end
                4: begin
                    write_limit(REG_NEAR_LIMIT, 20'($urandom_range(20000)));
                    write_limit(REG_MID_LIMIT, 20'($urandom_range(40000)));
                end
                default: begin
                    write_limit(REG_NEAR_LIMIT, 20'd0);
                    write_limit(REG_MID_LIMIT, 20'hFFFFF);
                end
            endcase
            send_idle_pct  = (ph < 2) ? 15 : (ph < 4) ? 77 : 0;
            recv_stall_pct = (ph < 2) ? 77 : (ph < 4) ? 15 : 0;
            for (int i = 0; i < 315; i++) begin
                random_query();
                // Sender holds off until the pipeline is empty, then resumes.
                if (i == 150) drain();
            end
        end

        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Covered %0d queries over %0d limit writes, zero distance, saturation,",
                 n_queries, n_configs);
        $display("band edges and sender/receiver stall mixes.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
